// ----- src/tfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tfb_pkg;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   // Job queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_BYTE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_ADDR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   // Register reset values
   localparam logic [BYTE_W-1:0] HEAD_BYTE_RST   = 8'hAA;
   localparam logic [BYTE_W-1:0] DEST_ADDR_RST   = 8'hFF;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd30;

   // Input commands
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_BYTE       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_LEN_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_OUTSIDE    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_START_OPEN = 2'd3;

   // What the back end has to do for one queued job
   typedef enum logic [1:0] {
      KIND_STAT,
      KIND_HDR,
      KIND_DATA
   } job_kind_type;

   // Byte sequencer steps in the back end
   typedef enum logic [2:0] {
      ST_FIRST,
      ST_DEST,
      ST_FUNC,
      ST_LEN,
      ST_SUM,
      ST_ADD
   } step_type;

   // One queued job. byte0 is func_code or data_byte, byte1 is payload_len.
   typedef struct packed {
      job_kind_type          kind;
      logic [STATUS_W-1:0]   status;
      logic                  close;
      logic [BYTE_W-1:0]     byte0;
      logic [BYTE_W-1:0]     byte1;
   } job_type;

   // Frame constants the back end places in the header
   typedef struct packed {
      logic [BYTE_W-1:0] head_byte;
      logic [BYTE_W-1:0] dest_addr;
   } hdr_cfg_type;

   // Queue handshake between the parts
   typedef struct packed {
      logic push;
      logic full;
   } q_wr_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } q_rd_type;

endpackage

`default_nettype wire

// ----- src/tfb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tfb_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  tfb_pkg::job_type     push_job,
   output logic                 full,
   input  wire                  pop,
   output tfb_pkg::job_type     head_job,
   output logic                 empty
);
   import tfb_pkg::*;

   job_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = QUEUE_CW'(count_ff + 1'b1);
         2'b01:   count_in = QUEUE_CW'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- src/tfb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tfb_front (
   input  wire                                clock,
   input  wire                                reset,
   // csr port
   input  wire                                csr_write_en,
   input  wire [tfb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [tfb_pkg::BYTE_W-1:0]          csr_wdata,
   // request channel
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_cmd,
   input  wire [tfb_pkg::BYTE_W-1:0]          req_func_code,
   input  wire [tfb_pkg::BYTE_W-1:0]          req_payload_len,
   input  wire [tfb_pkg::BYTE_W-1:0]          req_data_byte,
   // to queue and back end
   output tfb_pkg::q_wr_type                  q_wr,
   input  wire                                q_full,
   output tfb_pkg::job_type                   job,
   output tfb_pkg::hdr_cfg_type               hdr_cfg
);
   import tfb_pkg::*;

   logic [BYTE_W-1:0] head_byte_ff, dest_addr_ff, max_payload_ff;
   logic              frame_open_ff, frame_open_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic              accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_wr.push = accept;
   assign q_wr.full = q_full;

   assign hdr_cfg.head_byte = head_byte_ff;
   assign hdr_cfg.dest_addr = dest_addr_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_byte_ff   <= HEAD_BYTE_RST;
         dest_addr_ff   <= DEST_ADDR_RST;
         max_payload_ff <= MAX_PAYLOAD_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_HEAD_BYTE:   head_byte_ff   <= csr_wdata;
            CSR_DEST_ADDR:   dest_addr_ff   <= csr_wdata;
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // Classify the incoming word and track the frame state
   always_comb begin
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      job.kind      = KIND_STAT;
      job.status    = STAT_BYTE;
      job.close     = 1'b0;
      job.byte0     = req_func_code;
      job.byte1     = req_payload_len;
      if (req_cmd == CMD_START) begin
         if (frame_open_ff) begin
            job.status = STAT_START_OPEN;
         end else if (req_payload_len > max_payload_ff) begin
            job.status = STAT_LEN_REJECT;
         end else begin
            job.kind      = KIND_HDR;
            job.close     = (req_payload_len == '0);
            frame_open_in = (req_payload_len != '0);
            bytes_left_in = req_payload_len;
         end
      end else begin
         job.byte0 = req_data_byte;
         if (!frame_open_ff) begin
            job.status = STAT_OUTSIDE;
         end else begin
            job.kind      = KIND_DATA;
            job.close     = (bytes_left_ff == BYTE_W'(1));
            frame_open_in = !job.close;
            bytes_left_in = BYTE_W'(bytes_left_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else if (accept) begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/tfb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tfb_back (
   input  wire                                clock,
   input  wire                                reset,
   input  tfb_pkg::job_type                   head_job,
   input  tfb_pkg::hdr_cfg_type               hdr_cfg,
   output tfb_pkg::q_rd_type                  q_rd,
   input  wire                                q_empty,
   // result channel
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [tfb_pkg::BYTE_W-1:0]         rsp_frame_byte,
   output logic                               rsp_frame_end,
   output logic                               rsp_run_last,
   output logic [tfb_pkg::STATUS_W-1:0]       rsp_status
);
   import tfb_pkg::*;

   step_type            step_ff, step_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]   add_ff, add_in;
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic                rsp_end_ff, rsp_last_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                can_load, advance, done, fold_en, restart;
   logic [BYTE_W-1:0]   out_byte, sum_base, add_base;
   logic                out_end, out_last;
   logic [STATUS_W-1:0] out_status;

   // Output register frees as the downstream takes its word
   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign advance  = can_load && !q_empty;
   assign q_rd.pop   = advance && done;
   assign q_rd.empty = q_empty;

   // Step through the bytes of the job at the queue head
   always_comb begin
      step_in    = step_ff;
      done       = 1'b0;
      fold_en    = 1'b0;
      restart    = 1'b0;
      out_byte   = '0;
      out_end    = 1'b0;
      out_last   = 1'b0;
      out_status = STAT_BYTE;
      case (step_ff)
         ST_FIRST: begin
            case (head_job.kind)
               KIND_HDR: begin
                  out_byte = hdr_cfg.head_byte;
                  fold_en  = 1'b1;
                  restart  = 1'b1;
                  step_in  = ST_DEST;
               end
               KIND_DATA: begin
                  out_byte = head_job.byte0;
                  fold_en  = 1'b1;
                  out_last = !head_job.close;
                  done     = !head_job.close;
                  step_in  = head_job.close ? ST_SUM : ST_FIRST;
               end
               default: begin
                  out_status = head_job.status;
                  out_last   = 1'b1;
                  done       = 1'b1;
               end
            endcase
         end
         ST_DEST: begin
            out_byte = hdr_cfg.dest_addr;
            fold_en  = 1'b1;
            step_in  = ST_FUNC;
         end
         ST_FUNC: begin
            out_byte = head_job.byte0;
            fold_en  = 1'b1;
            step_in  = ST_LEN;
         end
         ST_LEN: begin
            out_byte = head_job.byte1;
            fold_en  = 1'b1;
            out_last = !head_job.close;
            done     = !head_job.close;
            step_in  = head_job.close ? ST_SUM : ST_FIRST;
         end
         ST_SUM: begin
            out_byte = sum_ff;
            step_in  = ST_ADD;
         end
         ST_ADD: begin
            out_byte = add_ff;
            out_end  = 1'b1;
            out_last = 1'b1;
            done     = 1'b1;
            step_in  = ST_FIRST;
         end
         default: begin
            done    = 1'b1;
            step_in = ST_FIRST;
         end
      endcase
   end

   // Running checks; a new frame starts both from zero
   always_comb begin
      sum_base = restart ? '0 : sum_ff;
      add_base = restart ? '0 : add_ff;
      sum_in   = BYTE_W'(sum_base + out_byte);
      add_in   = BYTE_W'(add_base + sum_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_FIRST;
         sum_ff  <= '0;
         add_ff  <= '0;
      end else if (advance) begin
         step_ff <= step_in;
         if (fold_en) begin
            sum_ff <= sum_in;
            add_ff <= add_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (can_load) begin
         rsp_valid_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff   <= out_byte;
         rsp_end_ff    <= out_end;
         rsp_last_ff   <= out_last;
         rsp_status_ff <= out_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_end  = rsp_end_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

// ----- src/telemetry_frame_builder_core.sv -----
// The first result word of an item passes through the job queue and then the result register.
// Payload words stream at one per cycle while the output is not stalled and jobs are queued; a start
// item yields four result words (six with an empty payload), the closing payload word three, a status word one.
// The four-entry job queue between front and back lets input run ahead of the output.
// Reset (synchronous, active high) restores register defaults and closes any frame.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_builder_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_write_en,
   input  wire [tfb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [tfb_pkg::BYTE_W-1:0]          csr_wdata,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_cmd,
   input  wire [tfb_pkg::BYTE_W-1:0]          req_func_code,
   input  wire [tfb_pkg::BYTE_W-1:0]          req_payload_len,
   input  wire [tfb_pkg::BYTE_W-1:0]          req_data_byte,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [tfb_pkg::BYTE_W-1:0]         rsp_frame_byte,
   output logic                               rsp_frame_end,
   output logic                               rsp_run_last,
   output logic [tfb_pkg::STATUS_W-1:0]       rsp_status
);
   import tfb_pkg::*;

   q_wr_type    q_wr;
   q_rd_type    q_rd;
   job_type     push_job, head_job;
   hdr_cfg_type hdr_cfg;
   logic        q_full, q_empty;

   tfb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_func_code   (req_func_code),
      .req_payload_len (req_payload_len),
      .req_data_byte   (req_data_byte),
      .q_wr            (q_wr),
      .q_full          (q_full),
      .job             (push_job),
      .hdr_cfg         (hdr_cfg)
   );

   tfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_wr.push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_rd.pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   tfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .hdr_cfg        (hdr_cfg),
      .q_rd           (q_rd),
      .q_empty        (q_empty),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_run_last   (rsp_run_last),
      .rsp_status     (rsp_status)
   );

   // Status words carry no byte and always end their item
   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_BYTE) |->
         (rsp_frame_byte == '0) && rsp_run_last && !rsp_frame_end)
      else $error("status word with byte or frame end");

   // The final check byte also closes the item that caused it
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last && (rsp_status == STAT_BYTE))
      else $error("frame end without run_last");

   // No word is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Nothing can be popped from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_rd.pop |-> !q_rd.empty)
      else $error("job queue underrun");

   // Nothing is pushed into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> !q_wr.full)
      else $error("job queue overrun");

endmodule

`default_nettype wire
